[rtl/core/srsm_pkg.sv]
// Package for the streaming regular expression matcher: sizes, register codes, pattern metachars.
`default_nettype none
package srsm_pkg;

  localparam int PATTERN_MAX_DEFAULT = 16;
  localparam int PATTERN_MAX_LIMIT   = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int CHAR_W      = 8;
  localparam int LENGTH_REG_W = 5;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

  // Pattern metacharacters
  localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;  // ^
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;  // *
  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;  // $
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;  // .
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;

endpackage
`default_nettype wire

[rtl/core/simple_regex_stream_matcher.sv]
// Top level of the streaming regular expression matcher: automaton state and result register.
`default_nettype none
// Streaming matcher for a small regular expression held in three configuration
// registers (pattern bytes 0-7, pattern bytes 8-15, pattern length). Text comes
// in one character per input transaction; an end transaction (end_of_text high,
// or a zero character) closes the text and yields one result transaction whose
// matched bit says whether the pattern occurred anywhere in that text. Non-end
// transactions yield nothing. The pattern knows a leading ^, a trailing $, '.'
// and 'c*'; every other byte is a literal, and the pattern stops at its first
// zero byte or at PATTERN_MAX characters. The automaton keeps one live bit per
// pattern position and updates all of them in parallel, so one character is
// taken in every cycle; the figure is set by the single state register and the
// position-closure logic in front of it. A result appears in the cycle after its end
// transaction and waits in the output register; the next character is still
// accepted when that result is taken in the same cycle, and is held off while
// the result waits untaken.
// There is no clearing pass after reset. Write configuration only while idle;
// a write inside a text keeps the live positions and reads them against the
// new pattern from the next character on.
module simple_regex_stream_matcher #(
  parameter int PATTERN_MAX = srsm_pkg::PATTERN_MAX_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // character channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [srsm_pkg::CHAR_W-1:0]      text_char,
  input  wire logic                             end_of_text,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  matched,
  // configuration write channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [srsm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [srsm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import srsm_pkg::*;

  localparam int PW = PATTERN_MAX + 1;          // positions 0..PATTERN_MAX
  localparam int LW = $clog2(PATTERN_MAX + 1);  // effective length width
  localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;  // character index
  localparam logic [LENGTH_REG_W-1:0] LIM_MAX = LENGTH_REG_W'(PATTERN_MAX);

  // configuration registers
  logic [CFG_DATA_W-1:0]   pattern_bytes_low;
  logic [CFG_DATA_W-1:0]   pattern_bytes_high;
  logic [LENGTH_REG_W-1:0] pattern_length;

  // automaton state
  logic [PW-1:0] active_positions;
  logic          found_flag;
  logic          at_text_start;

  logic [CHAR_W-1:0]       pchar [PATTERN_MAX];
  logic [2*CFG_DATA_W-1:0] pattern_all;
  logic [LENGTH_REG_W-1:0] lim;
  logic [LW-1:0]           len;
  logic [LW-1:0]           len_m1;
  logic [PW-1:0]           in_use;      // position below the effective length
  logic [PW-1:0]           len_mask;    // position at or below the effective length
  logic [PW-1:0]           star_head;
  logic                    anchored;
  logic [PW-1:0]           arm_set;
  logic                    arm_found;
  logic [PW-1:0]           cur;
  logic                    cur_found;
  logic [PW-1:0]           step_set;
  logic [PW-1:0]           active_positions_next;
  logic                    found_flag_next;
  logic                    is_end;
  logic                    match_now;
  logic                    in_fire;

  // Follow every starred position to the one after its star.
  function automatic logic [PW-1:0] close_set(input logic [PW-1:0] set_in,
                                              input logic [PW-1:0] heads);
    logic [PW-1:0] s;
    s = set_in;
    for (int i = 0; i + 2 < PW; i++) begin
      if (s[i] && heads[i]) s[i+2] = 1'b1;
    end
    return s;
  endfunction

  assign pattern_all = {pattern_bytes_high, pattern_bytes_low};

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      pchar[i] = pattern_all[CHAR_W*i +: CHAR_W];
    end
  end

  // Effective length: clamp, then stop at the first zero byte.
  assign lim = (pattern_length > LIM_MAX) ? LIM_MAX : pattern_length;

  always_comb begin
    len = LW'(PATTERN_MAX);
    for (int i = PATTERN_MAX - 1; i >= 0; i--) begin
      if (LENGTH_REG_W'(i) >= lim || pchar[i] == CH_NUL) len = LW'(i);
    end
  end

  assign len_m1 = len - LW'(1);

  always_comb begin
    for (int i = 0; i < PW; i++) begin
      in_use[i]   = LW'(i) < len;
      len_mask[i] = LW'(i) <= len;
      star_head[i] = 1'b0;
      if (i + 1 < PATTERN_MAX) begin
        star_head[i] = (LW'(i + 1) < len) && (pchar[i+1] == CH_STAR);
      end
    end
  end

  assign anchored = (len != '0) && (pchar[0] == CH_CARET);

  // Start set of a fresh text under the current pattern.
  always_comb begin
    logic [PW-1:0] start;
    start = '0;
    if (anchored) start[1] = 1'b1;
    else          start[0] = 1'b1;
    arm_set   = close_set(start, star_head);
    arm_found = arm_set[len];
  end

  // Live set seen by this character: re-armed on the first of a text.
  assign cur       = (at_text_start ? arm_set : active_positions) & len_mask;
  assign cur_found = at_text_start ? arm_found : found_flag;

  assign is_end = end_of_text || (text_char == CH_NUL);

  // A trailing $ is satisfied by the end of text itself.
  assign match_now = cur_found || cur[len] ||
                     ((len != '0) && (pchar[len_m1[IW-1:0]] == CH_DOLLAR) && cur[len_m1]);

  // Advance every live position over the character.
  always_comb begin
    logic [PW-1:0] nxt;
    logic          hit;
    nxt = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      hit = (pchar[i] == CH_DOT) || (pchar[i] == text_char);
      if (cur[i] && in_use[i]) begin
        if (star_head[i]) begin
          if (hit) nxt[i] = 1'b1;
        end else if (pchar[i] == CH_DOLLAR && LW'(i + 1) == len) begin
          // drop: this path needs the end of text
        end else if (hit) begin
          nxt[i+1] = 1'b1;
        end
      end
    end
    if (!anchored) nxt[0] = 1'b1;
    step_set = close_set(nxt, star_head);
  end

  assign active_positions_next = step_set;
  assign found_flag_next       = cur_found || step_set[len];

  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes_low  <= '0;
      pattern_bytes_high <= '0;
      pattern_length     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PATTERN_LOW:    pattern_bytes_low  <= cfg_data;
        CFG_PATTERN_HIGH:   pattern_bytes_high <= cfg_data;
        CFG_PATTERN_LENGTH: pattern_length     <= cfg_data[LENGTH_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // automaton state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_positions <= PW'(1);
      found_flag       <= 1'b0;
      at_text_start    <= 1'b1;
      out_valid        <= 1'b0;
    end else begin
      if (in_fire && is_end) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        if (is_end) begin
          // hold the answer and re-arm on the next character
          at_text_start <= 1'b1;
        end else begin
          active_positions <= active_positions_next;
          found_flag       <= found_flag_next;
          at_text_start    <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_end) matched <= match_now;
  end

  // An end transaction always leaves a result for the output side.
  assert property (@(posedge clk) disable iff (rst)
    in_fire && is_end |=> out_valid)
    else $error("end transaction left no result");

  // A character transaction never makes a result appear.
  assert property (@(posedge clk) disable iff (rst)
    in_fire && !is_end && !(out_valid && !out_ready) |=> !out_valid)
    else $error("result raised by a character transaction");

  // The empty pattern matches every text that it governs from the start.
  assert property (@(posedge clk) disable iff (rst)
    in_fire && is_end && at_text_start && len == '0 |=> matched)
    else $error("empty pattern reported no match");

  // A found match stays found until the text ends.
  assert property (@(posedge clk) disable iff (rst)
    in_fire && !is_end && cur_found |=> found_flag)
    else $error("found flag lost inside a text");

endmodule
`default_nettype wire
